@@ rtl/core/b64d_pkg.sv @@
// Shared types, codes and the character map of the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

   // request kinds
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR   = 2'd1;
   localparam logic [1:0] ST_EARLY_PAD  = 2'd2;
   localparam logic [1:0] ST_INCOMPLETE = 2'd3;

   // last position of a group
   localparam logic [1:0] POS_LAST = 2'd3;

   // result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_PUSH    = 3;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] data_byte;
      logic [1:0] status_code;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0]            count;
      result_type [MAX_PUSH-1:0] entry;
   } push_type;

   // bit 7 = bad character, bit 6 = pad mark, bits 5..0 = symbol value
   function automatic logic [7:0] classify(input logic [7:0] c);
      logic [7:0] sym;
      sym = 8'h80;
      case (c) inside
         [8'h41:8'h5A]: sym = c - 8'h41;
         [8'h61:8'h7A]: sym = c - 8'h61 + 8'd26;
         [8'h30:8'h39]: sym = c - 8'h30 + 8'd52;
         8'h2B:         sym = 8'd62;
         8'h2F:         sym = 8'd63;
         8'h3D:         sym = 8'h40;
         default:       sym = 8'h80;
      endcase
      return sym;
   endfunction

endpackage

@@ rtl/core/b64d_if.sv @@
// Request and response channel interfaces of the base64 stream decoder.
`timescale 1ns / 1ps

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_code;

   modport source (output valid, output req_type, output char_code, input ready);
   modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] data_byte;
   logic [1:0] status_code;
   logic       last_of_run;

   modport source (output valid, output item_kind, output data_byte,
                   output status_code, output last_of_run, input ready);
   modport sink   (input valid, input item_kind, input data_byte,
                   input status_code, input last_of_run, output ready);
endinterface

@@ rtl/core/base64_stream_decoder_unit.sv @@
// Top level of the base64 stream decoder: input stage, decode and result queue.
// A request is held in the input register, and any results it yields are written
//   into the queue, which offers them from its registered entries.
// Throughput: one request transaction per cycle while the queue has room; the
//   consumer drains one transaction per cycle from an 8-entry queue when ready.
// Requests stall only when fewer than three queue entries are free.
// Reset (synchronous, active high) clears group state, error latch and queue.
`timescale 1ns / 1ps

module base64_stream_decoder_unit
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req,
   b64d_rsp_if.source  rsp
);

   // decode stage -> queue: up to three results per character
   push_type push;
   // queue has room for a whole group's worth of bytes
   logic     space_ok;

   // input register, symbol map and group assembly
   b64d_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .space_ok (space_ok),
      .push     (push)
   );

   // results leave one per transaction, in order
   b64d_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp)
   );

endmodule

@@ rtl/core/b64d_decode.sv @@
// Input register, group state and symbol decode of the base64 stream decoder.
`timescale 1ns / 1ps

module b64d_decode
   import b64d_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   b64d_req_if.sink  req,
   input  logic      space_ok,
   output push_type  push
);

   logic       in_valid_ff, in_valid_in;
   logic       in_type_ff;
   logic [7:0] in_char_ff;
   logic       fire;

   logic [1:0] pos_ff, pos_in;
   logic [6:0] held_ff [3];
   logic [6:0] held_in [3];
   logic [1:0] error_ff, error_in;

   logic [7:0] sym;
   logic       p2, p3;
   logic [5:0] v2, v3;
   logic [7:0] b0, b1, b2;
   logic [1:0] st;
   logic [1:0] k;

   assign fire      = in_valid_ff && space_ok;
   assign req.ready = !in_valid_ff || space_ok;
   assign in_valid_in = req.valid ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req.valid && req.ready) begin
         in_type_ff <= req.req_type;
         in_char_ff <= req.char_code;
      end
   end

   always_comb begin
      sym = classify(in_char_ff);
      p2  = held_ff[2][6];
      p3  = sym[6];
      v2  = p2 ? 6'd0 : held_ff[2][5:0];
      v3  = p3 ? 6'd0 : sym[5:0];
      b0  = {held_ff[0][5:0], held_ff[1][5:4]};
      b1  = {held_ff[1][3:0], v2[5:2]};
      b2  = {v2[1:0], v3};
      st  = error_ff;
      k   = 2'd1;

      pos_in     = pos_ff;
      held_in    = held_ff;
      error_in   = error_ff;
      push       = '0;

      if (fire) begin
         if (in_type_ff == REQ_END) begin
            if (error_ff == ST_OK && pos_ff != 2'd0) begin
               st = ST_INCOMPLETE;
            end
            push.count = 2'd1;
            push.entry[0] = '{item_kind: KIND_STATUS, data_byte: 8'd0,
                              status_code: st, last_of_run: 1'b1};
            pos_in   = 2'd0;
            held_in  = '{default: 7'd0};
            error_in = ST_OK;
         end else if (error_ff == ST_OK) begin
            if (sym[7]) begin
               error_in = ST_BAD_CHAR;
            end else if (pos_ff != POS_LAST) begin
               held_in[pos_ff] = sym[6:0];
               pos_in = pos_ff + 2'd1;
            end else begin
               pos_in = 2'd0;
               if (held_ff[0][6] || held_ff[1][6]) begin
                  error_in = ST_EARLY_PAD;
               end else begin
                  push.entry[0] = '{KIND_DATA, b0, ST_OK, 1'b0};
                  if (!p2) begin
                     push.entry[k] = '{KIND_DATA, b1, ST_OK, 1'b0};
                     k = k + 2'd1;
                  end
                  if (!p3) begin
                     push.entry[k] = '{KIND_DATA, b2, ST_OK, 1'b0};
                     k = k + 2'd1;
                  end
                  push.count = k;
                  push.entry[k - 2'd1].last_of_run = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         held_ff  <= '{default: 7'd0};
         error_ff <= ST_OK;
      end else begin
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         error_ff <= error_in;
      end
   end

`ifndef SYNTH
   // a latched error only clears on an end-of-text transaction
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (error_ff != ST_OK && !(fire && in_type_ff == REQ_END)) |=> error_ff == $past(error_ff))
      else $error("error latch changed without end of text");
   // no data leaves once an error is latched
   a_silent_on_error: assert property (@(posedge clock) disable iff (reset)
      (error_ff != ST_OK && in_type_ff == REQ_CHAR) |-> push.count == 2'd0)
      else $error("data pushed after error");
   // end of text leaves the block in its reset state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && in_type_ff == REQ_END) |=> (pos_ff == 2'd0 && error_ff == ST_OK))
      else $error("state not cleared by end of text");
`endif

endmodule

@@ rtl/core/b64d_result_queue.sv @@
// Result queue of the base64 stream decoder: up to three writes, one read a cycle.
`timescale 1ns / 1ps

module b64d_result_queue
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        space_ok,
   b64d_rsp_if.source  rsp
);

   result_type         mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pop;
   result_type         head;

   assign space_ok = count_ff <= COUNT_W'(QUEUE_DEPTH - MAX_PUSH);
   assign pop      = rsp.valid && rsp.ready;
   assign head     = mem[rd_ptr_ff];

   assign rsp.valid       = count_ff != '0;
   assign rsp.item_kind   = head.item_kind;
   assign rsp.data_byte   = head.data_byte;
   assign rsp.status_code = head.status_code;
   assign rsp.last_of_run = head.last_of_run;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + COUNT_W'(push.count) - COUNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push.count) begin
            mem[wr_ptr_ff + PTR_W'(i)] <= push.entry[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok)
      else $error("push without room");
   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(wr_ptr_ff - rd_ptr_ff) == PTR_W'(count_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule
